// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication on every clock edge outside reset
`define CHK_IMPL(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Check a property with no reset qualification
`define CHK_ALWAYS(label, clk, cond, msg) \
  label: assert property (@(posedge clk) (cond)) else $error(msg);
`endif

// ===== rtl/core/cjs_pkg.sv =====
// ----------------------------------------------------------------------------
// cjs_pkg
// Shared types and codes of the job scheduler core.
// ----------------------------------------------------------------------------
package cjs_pkg;
  localparam logic [2:0] POL_FIFO     = 3'd0;
  localparam logic [2:0] POL_SJF      = 3'd1;
  localparam logic [2:0] POL_SRTF     = 3'd2;
  localparam logic [2:0] POL_PRIO     = 3'd3;
  localparam logic [2:0] POL_PRIO_PRE = 3'd4;
  localparam logic [2:0] POL_RR       = 3'd5;

  localparam logic CFG_POLICY  = 1'b0;
  localparam logic CFG_QUANTUM = 1'b1;

  // Controller commands to the datapath
  typedef struct packed {
    logic load;      // latch the input item
    logic do_add;    // append latched job
    logic preempt;   // push running job to tail
    logic scan_init; // start minimum search
    logic scan_step; // compare one entry
    logic take;      // move best entry to running slot
    logic shift;     // close one gap step
    logic run;       // run running job one unit
    logic finish;    // latch the result
  } cjs_cmd_t;

  // Datapath status to the controller
  typedef struct packed {
    logic is_tick;
    logic is_preempt_pol;
    logic running_valid;
    logic table_empty;
    logic scan_last;
    logic shift_last;
  } cjs_sts_t;
endpackage

// ===== rtl/core/cjs_ctrl.sv =====
// ----------------------------------------------------------------------------
// cjs_ctrl
// Sequencer for one item: add, or preempt / scan / take / shift / run.
// ----------------------------------------------------------------------------
module cjs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             out_valid,
  input  logic             out_stall,
  input  cjs_pkg::cjs_sts_t sts,
  output cjs_pkg::cjs_cmd_t cmd
);
  import cjs_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DEC   = 3'd1;
  localparam logic [2:0] ST_SEL   = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_SHIFT = 3'd4;
  localparam logic [2:0] ST_RUN   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  // Accept while idle; the output register holds a result until taken
  assign in_stall = (state != ST_IDLE) || (out_valid && out_stall);

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.load = 1'b1;
          state_next = ST_DEC;
        end
      end
      ST_DEC: begin
        if (!sts.is_tick) begin
          cmd.do_add = 1'b1;
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cmd.preempt = sts.is_preempt_pol && sts.running_valid;
          state_next = ST_SEL;
        end
      end
      ST_SEL: begin
        if (sts.running_valid || sts.table_empty) begin
          state_next = ST_RUN;
        end else begin
          cmd.scan_init = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.scan_last) begin
          cmd.take = 1'b1;
          state_next = ST_SHIFT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_SHIFT: begin
        if (sts.shift_last) begin
          state_next = ST_RUN;
        end else begin
          cmd.shift = 1'b1;
        end
      end
      ST_RUN: begin
        cmd.run = 1'b1;
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule

// ===== rtl/core/cjs_dp.sv =====
// ----------------------------------------------------------------------------
// cjs_dp
// Ready table memory, running slot, scan and shift counters, result register.
// ----------------------------------------------------------------------------
module cjs_dp #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  cjs_pkg::cjs_cmd_t cmd,
  output cjs_pkg::cjs_sts_t sts,
  input  logic             cfg_valid,
  input  logic             cfg_index,
  input  logic [7:0]       cfg_data,
  input  logic             mode,
  input  logic [7:0]       job_id,
  input  logic [15:0]      burst_length,
  input  logic [7:0]       job_priority,
  input  logic             out_stall,
  output logic             out_valid,
  output logic             add_accepted,
  output logic             ran,
  output logic [7:0]       ran_job_id,
  output logic             ran_job_done,
  output logic [4:0]       jobs_held
);
  import cjs_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  logic [31:0] mem [TABLE_DEPTH];
  logic [CW-1:0] count;
  logic [2:0]  policy;
  logic [7:0]  quantum;
  logic        rv;
  logic [7:0]  r_id;
  logic [15:0] r_burst;
  logic [7:0]  r_prio;
  logic [7:0]  slice;
  logic        l_mode;
  logic [7:0]  l_id;
  logic [15:0] l_burst;
  logic [7:0]  l_prio;
  logic [CW-1:0] idx;
  logic [IW-1:0] best;
  logic [15:0] best_key;
  logic        accepted;
  logic        ran_i;
  logic        done_i;

  logic by_prio, min_pol, preempt_pol, rr_pol;
  logic [31:0] rd;
  logic [15:0] rd_key;
  logic [15:0] burst_dec;
  logic [7:0]  slice_inc;
  logic [CW:0] held_sum;
  logic        can_add;

  assign by_prio = (policy == POL_PRIO) || (policy == POL_PRIO_PRE);
  assign min_pol = by_prio || (policy == POL_SJF) || (policy == POL_SRTF);
  assign preempt_pol = (policy == POL_SRTF) || (policy == POL_PRIO_PRE);
  assign rr_pol = (policy == POL_RR);
  assign rd = mem[idx[IW-1:0]];
  assign rd_key = by_prio ? {8'd0, rd[7:0]} : rd[23:8];
  assign burst_dec = r_burst - 16'd1;
  assign slice_inc = (slice == 8'hFF) ? slice : slice + 8'd1;
  assign held_sum = {1'b0, count} + {{CW{1'b0}}, rv};
  assign can_add = (l_burst != 16'd0) && (held_sum < {1'b0, DEPTH_C});

  assign sts.is_tick = l_mode;
  assign sts.is_preempt_pol = preempt_pol;
  assign sts.running_valid = rv;
  assign sts.table_empty = (count == '0);
  assign sts.scan_last = !min_pol || (idx >= count);
  // Count already excludes the taken entry; shift every slot after it down one place
  assign sts.shift_last = idx >= count;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= POL_FIFO;
      quantum <= 8'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_POLICY:  policy <= cfg_data[2:0];
        CFG_QUANTUM: quantum <= cfg_data;
        default: ;
      endcase
    end
  end

  // Table memory: one write a cycle (append, preempt push, shift or requeue of the running job)
  always_ff @(posedge clk) begin
    if (cmd.do_add && can_add) begin
      mem[count[IW-1:0]] <= {l_id, l_burst, l_prio};
    end else if (cmd.preempt) begin
      mem[count[IW-1:0]] <= {r_id, r_burst, r_prio};
    end else if (cmd.shift) begin
      mem[idx[IW-1:0]] <= mem[IW'(idx + CW'(1))];
    end else if (cmd.run && rv && burst_dec != 16'd0 &&
                 (preempt_pol || (rr_pol && slice_inc >= quantum))) begin
      mem[count[IW-1:0]] <= {r_id, burst_dec, r_prio};
    end
  end

  // Control state: count, running slot, scan pointer, result
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      rv <= 1'b0;
      slice <= 8'd0;
      out_valid <= 1'b0;
      idx <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cmd.do_add && can_add) count <= count + CW'(1);
      if (cmd.preempt) begin
        count <= count + CW'(1);
        rv <= 1'b0;
      end
      if (cmd.scan_init) begin
        idx <= CW'(1);
        best <= '0;
        best_key <= by_prio ? {8'd0, mem[0][7:0]} : mem[0][23:8];
      end
      if (cmd.scan_step) begin
        if (rd_key < best_key) begin
          best <= idx[IW-1:0];
          best_key <= rd_key;
        end
        idx <= idx + CW'(1);
      end
      if (cmd.take) begin
        rv <= 1'b1;
        slice <= 8'd0;
        r_id <= mem[min_pol ? best : '0][31:24];
        r_burst <= mem[min_pol ? best : '0][23:8];
        r_prio <= mem[min_pol ? best : '0][7:0];
        idx <= CW'(min_pol ? best : '0);
        count <= count - CW'(1);
      end
      if (cmd.shift) idx <= idx + CW'(1);
      if (cmd.run && rv) begin
        r_burst <= burst_dec;
        slice <= slice_inc;
        if (burst_dec == 16'd0) begin
          rv <= 1'b0;
        end else if (preempt_pol || (rr_pol && slice_inc >= quantum)) begin
          rv <= 1'b0;
          count <= count + CW'(1);
        end
      end
      if (cmd.finish) out_valid <= 1'b1;
    end
  end

  // Latch input item and result flags
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      l_mode <= mode;
      l_id <= job_id;
      l_burst <= burst_length;
      l_prio <= job_priority;
      accepted <= 1'b0;
      ran_i <= 1'b0;
      done_i <= 1'b0;
      ran_job_id <= 8'd0;
    end
    if (cmd.do_add) accepted <= can_add;
    if (cmd.run && rv) begin
      ran_i <= 1'b1;
      ran_job_id <= r_id;
      done_i <= (burst_dec == 16'd0);
    end
  end

  assign add_accepted = accepted;
  assign ran = ran_i;
  assign ran_job_done = done_i;
  assign jobs_held = 5'(held_sum);
endmodule

// ===== rtl/core/cpu_job_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// cpu_job_scheduler_core
// Job scheduler: ready table plus running slot under six policies.
// ----------------------------------------------------------------------------
// channel | handshake              | payload
// in      | in_valid / in_stall    | mode, job_id, burst_length, job_priority
// out     | out_valid / out_stall  | add_accepted, ran, ran_job_id, ...
// cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
// An add runs the accept and decode steps. A tick runs accept, decode and
// select, then, when a job is taken, a linear minimum scan over the table
// and a one-entry-a-cycle shift through the table memory, then the run step.
// Reset clears the counts and the running slot; no clearing pass.
// A result waits in the output register; the next item is held off until
// it is taken.
module cpu_job_scheduler_core #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [7:0]  job_id,
  input  logic [15:0] burst_length,
  input  logic [7:0]  job_priority,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        add_accepted,
  output logic        ran,
  output logic [7:0]  ran_job_id,
  output logic        ran_job_done,
  output logic [4:0]  jobs_held,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);
  import cjs_pkg::*;

  cjs_cmd_t cmd;
  cjs_sts_t sts;

  assign cfg_ready = 1'b1;

  cjs_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  cjs_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk, .rst, .cmd, .sts,
    .cfg_valid(cfg_valid && cfg_ready), .cfg_index, .cfg_data,
    .mode, .job_id, .burst_length, .job_priority,
    .out_stall, .out_valid, .add_accepted, .ran, .ran_job_id,
    .ran_job_done, .jobs_held
  );
endmodule

// ===== rtl/core/cjs_checker.sv =====
// ----------------------------------------------------------------------------
// cjs_checker
// Port-level checks of the scheduler core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module cjs_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       add_accepted,
  input logic       ran,
  input logic [7:0] ran_job_id,
  input logic       ran_job_done,
  input logic [4:0] jobs_held
);
  `CHK_IMPL(a_excl, clk, rst, out_valid |-> !(add_accepted && ran), "add and run together")
  `CHK_IMPL(a_idle_id, clk, rst, (out_valid && !ran) |-> (ran_job_id == 8'd0 && !ran_job_done), "id without run")
  `CHK_IMPL(a_one, clk, rst, (in_valid && !in_stall) |=> !out_valid, "result too early")
  `CHK_IMPL(a_hold, clk, rst, (out_valid && out_stall) |=> $stable(jobs_held), "held result changed")
  `CHK_ALWAYS(a_rst, clk, $past(rst) |-> !out_valid, "output valid after reset")
endmodule

bind cpu_job_scheduler_core cjs_checker u_chk (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
  .add_accepted, .ran, .ran_job_id, .ran_job_done, .jobs_held
);
